// ===== hdl/delay_scaled_cwnd_update_macros.svh =====
// assertion macros for the delay scaled cwnd update block
// used by the checker module, no other dependencies
`ifndef DELAY_SCALED_CWND_UPDATE_MACROS_SVH
`define DELAY_SCALED_CWND_UPDATE_MACROS_SVH

// same cycle implication
`define DSCU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next cycle implication
`define DSCU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/dscu_pkg.sv =====
// shared types and constants for the delay scaled cwnd update block
// no dependencies
package dscu_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MSS     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TARGET  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CEILING = 2'd2;

   localparam logic REQ_ACK  = 1'b0;
   localparam logic REQ_LOSS = 1'b1;

   // last step index of each serial operation
   localparam logic [5:0] MUL_LAST   = 6'd15;
   localparam logic [5:0] DIV32_LAST = 6'd31;
   localparam logic [5:0] DIV64_LAST = 6'd63;

   localparam logic [47:0] QD_DIVISOR = 48'd1000;

   typedef struct packed {
      logic        start;
      logic        op_div;
      logic [5:0]  last;
      logic [63:0] a;
      logic [47:0] b;
      logic [15:0] m;
   } dscu_cmd_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quo;
      logic [31:0] rem;
   } dscu_res_type;

endpackage

// ===== hdl/dscu_req_if.sv =====
// request channel of the delay scaled cwnd update block
// no dependencies
interface dscu_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [15:0] segments_acked;
   logic [31:0] rtt_sample_us;
   logic [31:0] last_rtt_us;
   logic [31:0] cwnd_bytes;
   logic [31:0] ssthresh_bytes;
   logic [31:0] bytes_in_flight;

   modport source (
      output valid, req_type, segments_acked, rtt_sample_us, last_rtt_us,
             cwnd_bytes, ssthresh_bytes, bytes_in_flight,
      input  ready
   );
   modport sink (
      input  valid, req_type, segments_acked, rtt_sample_us, last_rtt_us,
             cwnd_bytes, ssthresh_bytes, bytes_in_flight,
      output ready
   );
endinterface

// ===== hdl/dscu_rsp_if.sv =====
// response channel of the delay scaled cwnd update block
// no dependencies
interface dscu_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] new_cwnd_bytes;
   logic [31:0] new_ssthresh_bytes;
   logic [31:0] base_rtt_out_us;

   modport source (
      output valid, new_cwnd_bytes, new_ssthresh_bytes, base_rtt_out_us,
      input  ready
   );
   modport sink (
      input  valid, new_cwnd_bytes, new_ssthresh_bytes, base_rtt_out_us,
      output ready
   );
endinterface

// ===== hdl/delay_scaled_cwnd_update.sv =====
// Congestion window update engine: one word in, one word out. A loss word gives
// its result with no arithmetic, as does an ack with zero segments; a slow start
// ack runs one multiply of mss by segments; a congestion avoidance ack runs the
// square of mss, window divide and segment multiply, then the delay divide by 1000
// when queueing delay is measured, and the scale multiply and the final 64 bit
// rounding divide when it scales the growth. Each operation runs on the shared
// serial unit, which retires one multiplier or quotient bit per cycle. One word is
// worked at a time; the block is ready for the next word from the edge where the
// result appears, while that result may still wait on the response side, and a
// result held back by the response side delays the next one.
// Depends on dscu_pkg, dscu_req_if, dscu_rsp_if and dscu_serial_unit.
module delay_scaled_cwnd_update #(
   parameter int WINDOW_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [dscu_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dscu_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   dscu_req_if.sink                             req_ch,
   dscu_rsp_if.source                           rsp_ch
);
   import dscu_pkg::*;

   localparam logic [48:0] WMAX = (WINDOW_BITS >= 32) ? 49'hFFFF_FFFF
                                  : ((49'd1 << WINDOW_BITS) - 49'd1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECIDE, ST_SS, ST_SQ, ST_DIVW, ST_P, ST_QD, ST_NUM, ST_DEN, ST_DONE
   } state_type;

   state_type    state_ff, state_in;
   logic [15:0]  mss_ff, mss_in;
   logic [15:0]  tgt_ff, tgt_in;
   logic [15:0]  ceil_ff, ceil_in;
   logic [31:0]  base_ff, base_in;
   logic         loss_ff, loss_in;
   logic [15:0]  segs_ff, segs_in;
   logic [31:0]  last_ff, last_in;
   logic [31:0]  cwnd_ff, cwnd_in;
   logic [31:0]  ssth_ff, ssth_in;
   logic [31:0]  flight_ff, flight_in;
   logic [47:0]  p_ff, p_in;
   logic [47:0]  inc_ff, inc_in;
   dscu_cmd_type cmd_ff, cmd_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [31:0]  out_cwnd_ff, out_cwnd_in;
   logic [31:0]  out_ssth_ff, out_ssth_in;
   logic [31:0]  out_base_ff, out_base_in;

   dscu_res_type res;

   logic        accept;
   logic [31:0] delta;
   logic [31:0] qd;
   logic [15:0] den;
   logic [16:0] two_mss;
   logic [31:0] half_flight;
   logic [31:0] loss_ssth;
   logic [48:0] sum;
   logic [31:0] sat_cwnd;
   logic        round_up;

   dscu_serial_unit u_unit (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd_ff),
      .res   (res)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && (state_ff == ST_IDLE);

   always_comb begin
      delta       = (res.quo[31:0] == 32'd0) ? 32'd1 : res.quo[31:0];
      qd          = res.quo[31:0];
      den         = ceil_ff - tgt_ff;
      round_up    = {res.rem[15:0], 1'b0} >= {1'b0, den};
      two_mss     = {mss_ff, 1'b0};
      half_flight = {1'b0, flight_ff[31:1]};
      loss_ssth   = ({15'd0, two_mss} > half_flight) ? {15'd0, two_mss} : half_flight;
      sum         = {17'd0, cwnd_ff} + {1'b0, inc_ff};
      sat_cwnd    = (sum > WMAX) ? WMAX[31:0] : sum[31:0];

      state_in     = state_ff;
      mss_in       = mss_ff;
      tgt_in       = tgt_ff;
      ceil_in      = ceil_ff;
      base_in      = base_ff;
      loss_in      = loss_ff;
      segs_in      = segs_ff;
      last_in      = last_ff;
      cwnd_in      = cwnd_ff;
      ssth_in      = ssth_ff;
      flight_in    = flight_ff;
      p_in         = p_ff;
      inc_in       = inc_ff;
      cmd_in       = cmd_ff;
      cmd_in.start = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      out_cwnd_in  = out_cwnd_ff;
      out_ssth_in  = out_ssth_ff;
      out_base_in  = out_base_ff;

      if (csr_wr_en) begin
         case (csr_index)
            CSR_MSS:     mss_in  = csr_wdata;
            CSR_TARGET:  tgt_in  = csr_wdata;
            CSR_CEILING: ceil_in = csr_wdata;
            default:     ;
         endcase
      end

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               loss_in   = (req_ch.req_type == REQ_LOSS);
               segs_in   = req_ch.segments_acked;
               last_in   = req_ch.last_rtt_us;
               cwnd_in   = req_ch.cwnd_bytes;
               ssth_in   = req_ch.ssthresh_bytes;
               flight_in = req_ch.bytes_in_flight;
               // base rtt tracks the smallest nonzero sample
               if (req_ch.req_type == REQ_ACK && req_ch.rtt_sample_us != 32'd0 &&
                   (base_ff == 32'd0 || req_ch.rtt_sample_us < base_ff)) begin
                  base_in = req_ch.rtt_sample_us;
               end
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            inc_in = 48'd0;
            if (loss_ff || segs_ff == 16'd0) begin
               state_in = ST_DONE;
            end else if (cwnd_ff < ssth_ff) begin
               cmd_in = '{start: 1'b1, op_div: 1'b0, last: MUL_LAST,
                          a: 64'd0, b: {32'd0, mss_ff}, m: segs_ff};
               state_in = ST_SS;
            end else begin
               cmd_in = '{start: 1'b1, op_div: 1'b0, last: MUL_LAST,
                          a: 64'd0, b: {32'd0, mss_ff}, m: mss_ff};
               state_in = ST_SQ;
            end
         end
         ST_SS: begin
            if (res.done) begin
               inc_in   = res.quo[47:0];
               state_in = ST_DONE;
            end
         end
         ST_SQ: begin
            if (res.done) begin
               // zero window divides as one
               cmd_in = '{start: 1'b1, op_div: 1'b1, last: DIV32_LAST,
                          a: {res.quo[31:0], 32'd0},
                          b: {16'd0, ((cwnd_ff == 32'd0) ? 32'd1 : cwnd_ff)},
                          m: 16'd0};
               state_in = ST_DIVW;
            end
         end
         ST_DIVW: begin
            if (res.done) begin
               cmd_in = '{start: 1'b1, op_div: 1'b0, last: MUL_LAST,
                          a: 64'd0, b: {16'd0, delta}, m: segs_ff};
               state_in = ST_P;
            end
         end
         ST_P: begin
            if (res.done) begin
               p_in = res.quo[47:0];
               if (base_ff != 32'd0 && last_ff != 32'd0 && last_ff > base_ff) begin
                  cmd_in = '{start: 1'b1, op_div: 1'b1, last: DIV32_LAST,
                             a: {last_ff - base_ff, 32'd0}, b: QD_DIVISOR, m: 16'd0};
                  state_in = ST_QD;
               end else begin
                  inc_in   = res.quo[47:0];
                  state_in = ST_DONE;
               end
            end
         end
         ST_QD: begin
            if (res.done) begin
               if (qd >= {16'd0, ceil_ff}) begin
                  inc_in   = 48'd0;
                  state_in = ST_DONE;
               end else if (qd > {16'd0, tgt_ff}) begin
                  cmd_in = '{start: 1'b1, op_div: 1'b0, last: MUL_LAST,
                             a: 64'd0, b: p_ff, m: ceil_ff - qd[15:0]};
                  state_in = ST_NUM;
               end else begin
                  inc_in   = p_ff;
                  state_in = ST_DONE;
               end
            end
         end
         ST_NUM: begin
            if (res.done) begin
               cmd_in = '{start: 1'b1, op_div: 1'b1, last: DIV64_LAST,
                          a: res.quo, b: {32'd0, den}, m: 16'd0};
               state_in = ST_DEN;
            end
         end
         ST_DEN: begin
            if (res.done) begin
               // round half up on the remainder
               inc_in   = res.quo[47:0] + {47'd0, round_up};
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               out_cwnd_in  = loss_ff ? cwnd_ff : sat_cwnd;
               out_ssth_in  = loss_ff ? loss_ssth : ssth_ff;
               out_base_in  = base_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mss_ff       <= 16'd1448;
         tgt_ff       <= 16'd12;
         ceil_ff      <= 16'd70;
         base_ff      <= 32'd0;
         cmd_ff.start <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mss_ff       <= mss_in;
         tgt_ff       <= tgt_in;
         ceil_ff      <= ceil_in;
         base_ff      <= base_in;
         cmd_ff.start <= cmd_in.start;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff.op_div <= cmd_in.op_div;
      cmd_ff.last   <= cmd_in.last;
      cmd_ff.a      <= cmd_in.a;
      cmd_ff.b      <= cmd_in.b;
      cmd_ff.m      <= cmd_in.m;
      loss_ff       <= loss_in;
      segs_ff       <= segs_in;
      last_ff       <= last_in;
      cwnd_ff       <= cwnd_in;
      ssth_ff       <= ssth_in;
      flight_ff     <= flight_in;
      p_ff          <= p_in;
      inc_ff        <= inc_in;
      out_cwnd_ff   <= out_cwnd_in;
      out_ssth_ff   <= out_ssth_in;
      out_base_ff   <= out_base_in;
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.new_cwnd_bytes     = out_cwnd_ff;
   assign rsp_ch.new_ssthresh_bytes = out_ssth_ff;
   assign rsp_ch.base_rtt_out_us    = out_base_ff;

endmodule

// ===== hdl/dscu_serial_unit.sv =====
// shared one bit per cycle multiply and restoring divide unit
// depends on dscu_pkg
module dscu_serial_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  dscu_pkg::dscu_cmd_type cmd,
   output dscu_pkg::dscu_res_type res
);
   import dscu_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [47:0] b_ff, b_in;
   logic [15:0] mlt_ff, mlt_in;
   logic [31:0] rem_ff, rem_in;

   logic [32:0] rem_sh;
   logic        ge;
   logic [32:0] rem_sub;
   logic [63:0] addend;

   always_comb begin
      rem_sh  = {rem_ff, acc_ff[63]};
      ge      = rem_sh >= {1'b0, b_ff[31:0]};
      rem_sub = rem_sh - {1'b0, b_ff[31:0]};
      addend  = mlt_ff[15] ? {16'd0, b_ff} : 64'd0;

      busy_in = busy_ff;
      done_in = 1'b0;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      b_in    = b_ff;
      mlt_in  = mlt_ff;
      rem_in  = rem_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         div_in  = cmd.op_div;
         cnt_in  = cmd.last;
         acc_in  = cmd.op_div ? cmd.a : 64'd0;
         b_in    = cmd.b;
         mlt_in  = cmd.m;
         rem_in  = 32'd0;
      end else if (busy_ff) begin
         if (div_ff) begin
            rem_in = ge ? rem_sub[31:0] : rem_sh[31:0];
            acc_in = {acc_ff[62:0], ge};
         end else begin
            acc_in = {acc_ff[62:0], 1'b0} + addend;
            mlt_in = {mlt_ff[14:0], 1'b0};
         end
         if (cnt_ff == 6'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      div_ff <= div_in;
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      b_ff   <= b_in;
      mlt_ff <= mlt_in;
      rem_ff <= rem_in;
   end

   assign res.done = done_ff;
   assign res.quo  = acc_ff;
   assign res.rem  = rem_ff;

endmodule

// ===== hdl/dscu_checker.sv =====
// port level checks for the delay scaled cwnd update block, bound to the top level
// depends on delay_scaled_cwnd_update_macros.svh
`include "delay_scaled_cwnd_update_macros.svh"

module dscu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] new_cwnd_bytes,
   input logic [31:0] new_ssthresh_bytes,
   input logic [31:0] base_rtt_out_us
);

   // one word in flight: no accept right after an accept
   `DSCU_ASSERT_NEXT(a_single_word, clock, reset, req_valid && req_ready, !req_ready, "word accepted while busy")

   // reset leaves the block ready and with no response pending
   `DSCU_ASSERT_NEXT(a_reset_state, clock, 1'b0, reset, req_ready && !rsp_valid, "bad state after reset")

   `DSCU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   `DSCU_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(new_cwnd_bytes) && $stable(new_ssthresh_bytes) && $stable(base_rtt_out_us), "response changed while stalled")

endmodule

bind delay_scaled_cwnd_update dscu_checker u_dscu_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .new_cwnd_bytes     (rsp_ch.new_cwnd_bytes),
   .new_ssthresh_bytes (rsp_ch.new_ssthresh_bytes),
   .base_rtt_out_us    (rsp_ch.base_rtt_out_us)
);
